>>> sv/ira_pkg.sv
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types and constants for the interval room allocator.
// ----------------------------------------------------------------------------
package ira_pkg;

	localparam int TIME_W      = 32;
	localparam int ROOMS_OUT_W = 7;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic              new_set;
	} meet_item_t;

	typedef struct packed {
		logic [ROOMS_OUT_W-1:0] rooms_needed;
		logic                   room_reused;
		logic                   overflow;
	} room_result_t;

endpackage

>>> sv/ira_ram.sv
// ----------------------------------------------------------------------------
// ira_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ira_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

>>> sv/ira_front.sv
// ----------------------------------------------------------------------------
// ira_front
// Input side: takes meeting transactions into a short queue that decouples
// the port from the heap engine.
// ----------------------------------------------------------------------------
module ira_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                meet_valid,
	output logic                meet_stall,
	input  ira_pkg::meet_item_t meet_item,
	output logic                q_valid,
	output ira_pkg::meet_item_t q_item,
	input  logic                q_pop
);
	import ira_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	meet_item_t    slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          push;
	logic          pop;

	assign meet_stall = (fill_q == CW'(QUEUE_DEPTH));
	assign q_valid    = (fill_q != '0);
	assign q_item     = slot_q[rd_ptr_q];
	assign push       = meet_valid && !meet_stall;
	assign pop        = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= meet_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/ira_heap.sv
// ----------------------------------------------------------------------------
// ira_heap
// Heap engine: decides reuse, push or overflow for each meeting, sifts the
// end-time min-heap one level per cycle and holds the result register.
// ----------------------------------------------------------------------------
module ira_heap #(
	parameter int MAX_ROOMS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  ira_pkg::meet_item_t   q_item,
	output logic                  q_pop,
	output logic                  res_valid,
	input  logic                  res_stall,
	output ira_pkg::room_result_t res
);
	import ira_pkg::*;

	localparam int AW = $clog2(MAX_ROOMS);
	localparam int CW = $clog2(MAX_ROOMS + 1);
	localparam int IW = CW + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DOWN = 4'b0010,
		ST_UP   = 4'b0100,
		ST_ROOT = 4'b1000
	} heap_state_t;

	heap_state_t       state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic [TIME_W-1:0] val_q, val_d;
	logic [TIME_W-1:0] root_q;
	logic              res_valid_q;
	room_result_t      res_q, res_d;
	logic              finish;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [TIME_W-1:0] wdata;
	logic [AW-1:0]     raddr0, raddr1;
	logic [TIME_W-1:0] rdata0, rdata1;

	logic              go;
	logic [CW-1:0]     cnt;
	logic              reuse;
	logic [IW-1:0]     ridx;
	logic              lv, rv;
	logic              take_l, take_r;
	logic [TIME_W-1:0] lmin;
	logic [AW-1:0]     par;

	ira_ram #(
		.WIDTH(TIME_W),
		.DEPTH(MAX_ROOMS)
	) u_heap_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign go    = (state_q == ST_IDLE) && q_valid && (!res_valid_q || !res_stall);
	assign cnt   = q_item.new_set ? '0 : count_q;
	assign reuse = (cnt != '0) && (q_item.start_time >= root_q);

	assign par    = AW'((pos_q - 1'b1) >> 1);
	assign ridx   = IW'({pos_q, 1'b0}) + IW'(2);
	assign lv     = (IW'({pos_q, 1'b0}) + IW'(1)) < IW'(count_q);
	assign rv     = ridx < IW'(count_q);
	assign take_l = lv && (rdata0 < val_q);
	assign lmin   = take_l ? rdata0 : val_q;
	assign take_r = rv && (rdata1 < lmin);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d   = pos_q;
		val_d   = val_q;
		res_d   = res_q;
		finish  = 1'b0;
		q_pop   = 1'b0;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = val_q;
		raddr0  = '0;
		raddr1  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					q_pop = 1'b1;
					val_d = q_item.end_time;
					if (reuse) begin
						count_d = cnt;
						pos_d   = '0;
						raddr0  = AW'(1);
						raddr1  = AW'(2);
						state_d = ST_DOWN;
					end else if (cnt < CW'(MAX_ROOMS)) begin
						count_d = cnt + 1'b1;
						if (cnt == '0) begin
							we     = 1'b1;
							waddr  = '0;
							wdata  = q_item.end_time;
							finish = 1'b1;
							res_d  = '{ROOMS_OUT_W'(cnt + 1'b1), 1'b0, 1'b0};
						end else begin
							pos_d   = AW'(cnt);
							raddr0  = AW'((cnt - 1'b1) >> 1);
							state_d = ST_UP;
						end
					end else begin
						count_d = cnt;
						finish  = 1'b1;
						res_d   = '{ROOMS_OUT_W'(cnt), 1'b0, 1'b1};
					end
				end
			end
			ST_DOWN: begin
				we = 1'b1;
				if (take_l || take_r) begin
					wdata  = take_r ? rdata1 : rdata0;
					pos_d  = take_r ? AW'(ridx) : AW'(ridx - 1'b1);
					raddr0 = AW'({IW'(pos_d), 1'b0} + 1'b1);
					raddr1 = AW'({IW'(pos_d), 1'b0} + 2'd2);
				end else begin
					finish  = 1'b1;
					res_d   = '{ROOMS_OUT_W'(count_q), 1'b1, 1'b0};
					state_d = ST_IDLE;
				end
			end
			ST_UP: begin
				we = 1'b1;
				if (rdata0 <= val_q) begin
					finish  = 1'b1;
					res_d   = '{ROOMS_OUT_W'(count_q), 1'b0, 1'b0};
					state_d = ST_IDLE;
				end else begin
					wdata = rdata0;
					pos_d = par;
					if (par == '0) begin
						state_d = ST_ROOT;
					end else begin
						raddr0 = AW'((par - 1'b1) >> 1);
					end
				end
			end
			ST_ROOT: begin
				we      = 1'b1;
				waddr   = '0;
				finish  = 1'b1;
				res_d   = '{ROOMS_OUT_W'(count_q), 1'b0, 1'b0};
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		res_q <= res_d;
		if (we && (waddr == '0)) begin
			root_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/interval_room_allocator_unit.sv
// ----------------------------------------------------------------------------
// interval_room_allocator_unit
// Minimum meeting rooms: a min-heap of room end times, reused or grown per
// meeting, reporting the rooms in use after each transaction.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  meeting   meet_valid/meet_stall   start_time, end_time, new_set
//  result    res_valid/res_stall     rooms_needed, room_reused, overflow
//
//  With the engine free, the result of an overflow or of a push into an
//  empty heap is registered as the engine pops the meeting from the queue;
//  other meetings first sift the heap RAM one level a cycle, at most
//  log2(MAX_ROOMS) levels, in ST_DOWN for a reuse or in ST_UP for a push.
//  Reset empties the heap at once; the RAM itself is never cleared.
//  The queue takes transactions until full while a result waits on res_stall.
// ----------------------------------------------------------------------------
module interval_room_allocator_unit #(
	parameter int MAX_ROOMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        meet_valid,
	output logic        meet_stall,
	input  logic [31:0] start_time,
	input  logic [31:0] end_time,
	input  logic        new_set,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [6:0]  rooms_needed,
	output logic        room_reused,
	output logic        overflow
);
	import ira_pkg::*;

	meet_item_t   meet_item;
	meet_item_t   q_item;
	logic         q_valid;
	logic         q_pop;
	room_result_t res;

	assign meet_item = '{start_time, end_time, new_set};

	ira_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.meet_valid(meet_valid),
		.meet_stall(meet_stall),
		.meet_item (meet_item),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	ira_heap #(
		.MAX_ROOMS(MAX_ROOMS)
	) u_heap (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	assign rooms_needed = res.rooms_needed;
	assign room_reused  = res.room_reused;
	assign overflow     = res.overflow;

endmodule

>>> sv/ira_checker.sv
// ----------------------------------------------------------------------------
// ira_checker
// Port-level checks on the room allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ira_checker #(
	parameter int MAX_ROOMS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [6:0]  rooms_needed,
	input logic        room_reused,
	input logic        overflow
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(rooms_needed)
			&& $stable(room_reused) && $stable(overflow))
		else $error("result changed while stalled");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(room_reused && overflow))
		else $error("reuse and overflow both set");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow |-> rooms_needed == 7'(MAX_ROOMS))
		else $error("overflow without a full heap");

	a_no_early_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !res_valid)
		else $error("result straight out of reset");

endmodule

bind interval_room_allocator_unit ira_checker #(.MAX_ROOMS(MAX_ROOMS)) u_ira_checker (.*);

>>> tb/ira_room_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ira_room_checker
// Watches both channels of the room allocator and keeps its own min-heap of
// room end times. Each accepted meeting gives the rooms count, reuse and
// overflow flags that must come back. Each accepted result is compared with
// the oldest of those, field by field.
// ----------------------------------------------------------------------------
module ira_room_checker #(
	parameter int MAX_ROOMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        meet_valid,
	input  logic        meet_stall,
	input  logic [31:0] start_time,
	input  logic [31:0] end_time,
	input  logic        new_set,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [6:0]  rooms_needed,
	input  logic        room_reused,
	input  logic        overflow,
	output int          mismatches,
	output int          rooms_pending,
	output int          meetings_seen,
	output int          reuse_seen,
	output int          overflow_seen,
	output int          peak_rooms
);

	import ira_pkg::*;

	logic [31:0]  room_end_q [MAX_ROOMS];
	int unsigned  rooms_used;
	room_result_t rooms_due_q [$];

	task automatic predict_rooms(input logic [31:0] st, input logic [31:0] et,
			input logic fresh, output room_result_t res);
		int unsigned pos;
		int unsigned best;
		int unsigned lc;
		int unsigned rc;
		int unsigned parent;
		logic [31:0] tmp;
		bit          settled;
		res = '0;
		settled = 1'b0;
		if (fresh)
			rooms_used = 0;
		if (rooms_used > 0 && st >= room_end_q[0]) begin
			// earliest room is free again: replace its end and sift down
			room_end_q[0] = et;
			pos = 0;
			while (!settled) begin
				best = pos;
				lc = 2 * pos + 1;
				rc = 2 * pos + 2;
				if (lc < rooms_used && room_end_q[lc] < room_end_q[best])
					best = lc;
				if (rc < rooms_used && room_end_q[rc] < room_end_q[best])
					best = rc;
				if (best == pos) begin
					settled = 1'b1;
				end else begin
					tmp = room_end_q[pos];
					room_end_q[pos] = room_end_q[best];
					room_end_q[best] = tmp;
					pos = best;
				end
			end
			res.room_reused = 1'b1;
		end else if (rooms_used < MAX_ROOMS) begin
			room_end_q[rooms_used] = et;
			rooms_used++;
			pos = rooms_used - 1;
			while (pos > 0 && !settled) begin
				parent = (pos - 1) / 2;
				if (room_end_q[parent] <= room_end_q[pos]) begin
					settled = 1'b1;
				end else begin
					tmp = room_end_q[parent];
					room_end_q[parent] = room_end_q[pos];
					room_end_q[pos] = tmp;
					pos = parent;
				end
			end
		end else begin
			res.overflow = 1'b1;
		end
		res.rooms_needed = rooms_used[6:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		room_result_t due;
		room_result_t got;
		if (!arst_n) begin
			rooms_used = 0;
			rooms_due_q.delete();
			mismatches = 0;
			meetings_seen = 0;
			reuse_seen = 0;
			overflow_seen = 0;
			peak_rooms = 0;
		end else begin
			if (res_valid && !res_stall) begin
				got.rooms_needed = rooms_needed;
				got.room_reused = room_reused;
				got.overflow = overflow;
				if (rooms_due_q.size() == 0) begin
					$display("%0t: result with no meeting outstanding: rooms %0d reused %0b ovf %0b",
						$time, got.rooms_needed, got.room_reused, got.overflow);
					mismatches++;
				end else begin
					due = rooms_due_q.pop_front();
					if (got.rooms_needed !== due.rooms_needed) begin
						$display("%0t: rooms_needed expected %0d, got %0d",
							$time, due.rooms_needed, got.rooms_needed);
						mismatches++;
					end
					if (got.room_reused !== due.room_reused) begin
						$display("%0t: room_reused expected %0b, got %0b",
							$time, due.room_reused, got.room_reused);
						mismatches++;
					end
					if (got.overflow !== due.overflow) begin
						$display("%0t: overflow expected %0b, got %0b",
							$time, due.overflow, got.overflow);
						mismatches++;
					end
				end
			end
			if (meet_valid && !meet_stall) begin
				predict_rooms(start_time, end_time, new_set, due);
				rooms_due_q.push_back(due);
				meetings_seen++;
				if (due.room_reused)
					reuse_seen++;
				if (due.overflow)
					overflow_seen++;
				if (int'(rooms_used) > peak_rooms)
					peak_rooms = int'(rooms_used);
			end
		end
		rooms_pending = rooms_due_q.size();
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives meeting sets into the room allocator: a few hand-picked meetings,
// then random sets in start order, crowded sets that fill the heap and
// overflow, and unordered noise. Both channels idle at random, and the
// result side holds off for long stretches so the input backs up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ROOMS      = 64;
	localparam int MEET_COUNT = 1450;

	logic        clk;
	logic        arst_n;
	logic        meet_valid;
	logic        meet_stall;
	logic [31:0] start_time;
	logic [31:0] end_time;
	logic        new_set;
	logic        res_valid;
	logic        res_stall;
	logic [6:0]  rooms_needed;
	logic        room_reused;
	logic        overflow;

	int mismatches;
	int rooms_pending;
	int meetings_seen;
	int reuse_seen;
	int overflow_seen;
	int peak_rooms;

	int meetings_sent;
	int send_quiet;

	interval_room_allocator_unit #(
		.MAX_ROOMS(ROOMS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.meet_valid  (meet_valid),
		.meet_stall  (meet_stall),
		.start_time  (start_time),
		.end_time    (end_time),
		.new_set     (new_set),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.rooms_needed(rooms_needed),
		.room_reused (room_reused),
		.overflow    (overflow)
	);

	ira_room_checker #(
		.MAX_ROOMS(ROOMS)
	) room_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.meet_valid   (meet_valid),
		.meet_stall   (meet_stall),
		.start_time   (start_time),
		.end_time     (end_time),
		.new_set      (new_set),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.rooms_needed (rooms_needed),
		.room_reused  (room_reused),
		.overflow     (overflow),
		.mismatches   (mismatches),
		.rooms_pending(rooms_pending),
		.meetings_seen(meetings_seen),
		.reuse_seen   (reuse_seen),
		.overflow_seen(overflow_seen),
		.peak_rooms   (peak_rooms)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] sum;
		sum = a + b;
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer_meeting(input logic [31:0] st, input logic [31:0] et,
			input logic fresh);
		int gap;
		if (send_quiet > 0) begin
			send_quiet--;
			gap = 0;
		end else if ($urandom_range(0, 39) == 0) begin
			send_quiet = $urandom_range(20, 60);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 11);
		end
		if (gap != 0) begin
			meet_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start_time <= st;
		end_time <= et;
		new_set <= fresh;
		meet_valid <= 1'b1;
		do @(posedge clk); while (meet_stall);
		meetings_sent++;
		@(negedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("Timeout with %0d meetings sent, %0d results outstanding",
			meetings_sent, rooms_pending);
		$display("Regression FAIL");
		$finish;
	end

	// result side: random hold-off per result, quiet runs, two long holds
	initial begin
		int gap;
		int res_taken;
		int quiet_left;
		res_stall = 1'b0;
		res_taken = 0;
		quiet_left = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (res_taken == 250 || res_taken == 800) begin
				gap = 160;
			end else if (quiet_left > 0) begin
				quiet_left--;
				gap = 0;
			end else if ($urandom_range(0, 39) == 0) begin
				quiet_left = $urandom_range(20, 60);
				gap = 0;
			end else begin
				gap = $urandom_range(0, 11);
			end
			if (gap != 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (res_valid !== 1'b1);
			res_taken++;
			@(negedge clk);
		end
	end

	initial begin
		logic [31:0] st;
		logic [31:0] et;
		int          kind;
		int          span;
		int          n;
		meet_valid = 1'b0;
		start_time = '0;
		end_time = '0;
		new_set = 1'b0;
		meetings_sent = 0;
		send_quiet = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty heap, reuse on equal times, growth, clearing, unsigned compare
		offer_meeting(32'h0000_0000, 32'h0000_0000, 1'b1);
		offer_meeting(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		offer_meeting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		offer_meeting(32'h0000_0005, 32'h0000_000A, 1'b0);
		offer_meeting(32'h0000_000A, 32'h0000_0014, 1'b0);
		offer_meeting(32'h0000_0001, 32'h0000_0002, 1'b0);
		offer_meeting(32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
		offer_meeting(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		offer_meeting(32'h0000_0003, 32'h0000_0004, 1'b0);
		offer_meeting(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		offer_meeting(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		offer_meeting(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

		while (meetings_sent < MEET_COUNT) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// unordered noise, sets cleared at random
				n = $urandom_range(1, 8);
				repeat (n)
					offer_meeting($urandom, $urandom, $urandom_range(0, 3) == 0);
			end else if (kind == 1) begin
				// everyone overlaps: fills the heap, then overflows
				st = $urandom_range(0, 1000);
				n = $urandom_range(ROOMS + 2, ROOMS + 12);
				for (int i = 0; i < n; i++) begin
					et = {4'hF, 28'($urandom)};
					offer_meeting(st, et, i == 0);
					st = sat_add(st, $urandom_range(0, 3));
				end
				n = $urandom_range(2, 5);
				repeat (n)
					offer_meeting(32'hFFFF_FFFF, $urandom, 1'b0);
			end else begin
				st = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
				case ($urandom_range(0, 2))
					0: span = 10;
					1: span = 1000;
					default: span = 100000;
				endcase
				n = $urandom_range(2, 30);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 15) == 0)
						et = $urandom;
					else
						et = sat_add(st, $urandom_range(1, span));
					offer_meeting(st, et, i == 0);
					st = sat_add(st, $urandom_range(0, span / 4));
				end
			end
		end
		meet_valid <= 1'b0;

		while (rooms_pending != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		$display("Covered %0d meetings in start order, crowded and unordered sets",
			meetings_seen);
		$display("Rooms reused %0d times, %0d overflows, peak of %0d rooms in use",
			reuse_seen, overflow_seen, peak_rooms);
		if (mismatches == 0 && rooms_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
sv/ira_pkg.sv
sv/ira_ram.sv
sv/ira_front.sv
sv/ira_heap.sv
sv/interval_room_allocator_unit.sv
sv/ira_checker.sv
tb/ira_room_checker.sv
tb/testbench.sv
